// ----- rtl/core/bba_pkg.sv -----
// ---------------------------------------------------------------------------
// bba_pkg
// Shared constants for the buddy block allocator: default sizes, field
// widths and command codes.
// ---------------------------------------------------------------------------
package bba_pkg;

    localparam int DEF_POOL_BYTES        = 262144;
    localparam int DEF_MAX_BLOCK_BYTES   = 32768;
    localparam int DEF_HEADER_BYTES      = 32;
    localparam int DEF_MIN_REQUEST_BYTES = 32;

    localparam int CMD_W  = 2;
    localparam int REQ_W  = 16;
    localparam int ADDR_W = 18;
    localparam int USED_W = 19;

    localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REPORT = 2'd2;

endpackage

// ----- rtl/core/bba_ram.sv -----
// ---------------------------------------------------------------------------
// bba_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/buddy_block_allocator_core.sv -----
// ---------------------------------------------------------------------------
// buddy_block_allocator_core
// Buddy allocator over a pool with one header entry per minimum block unit.
// ---------------------------------------------------------------------------
// One item at a time. After reset a clearing pass writes all POOL_BYTES/unit
// header entries (4096 at the defaults, unit 64 bytes) before the first item.
// Block headers live in one RAM with a registered read. An allocate walks
// the blocks in address order and halves the first free block that fits
// while the half still holds the request; a free marks the block free and
// merges it with its free buddy until a buddy is not free and whole, the
// maximum block size or the pool size is reached. A report, an unknown
// command, an oversized request or a bad free give a result with no merge.
// The output register lets the next item be taken while a result waits.
// ---------------------------------------------------------------------------
module buddy_block_allocator_core #(
    parameter int POOL_BYTES        = bba_pkg::DEF_POOL_BYTES,
    parameter int MAX_BLOCK_BYTES   = bba_pkg::DEF_MAX_BLOCK_BYTES,
    parameter int HEADER_BYTES      = bba_pkg::DEF_HEADER_BYTES,
    parameter int MIN_REQUEST_BYTES = bba_pkg::DEF_MIN_REQUEST_BYTES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [bba_pkg::CMD_W-1:0]   command,
    input  logic [bba_pkg::REQ_W-1:0]   request_bytes,
    input  logic [bba_pkg::ADDR_W-1:0]  free_address,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        ok,
    output logic [bba_pkg::ADDR_W-1:0]  address,
    output logic [bba_pkg::USED_W-1:0]  used_bytes
);

    localparam int POOL_LOG = $clog2(POOL_BYTES);
    localparam int NEED_MIN = ((MIN_REQUEST_BYTES + 7) / 8) * 8 + HEADER_BYTES;
    localparam int UNIT_LOG = $clog2(NEED_MIN);
    localparam int DEPTH    = POOL_BYTES >> UNIT_LOG;
    localparam int AW       = $clog2(DEPTH);
    localparam int TOP_CODE = POOL_LOG - UNIT_LOG;
    localparam int CW       = $clog2(TOP_CODE + 1);
    localparam int EW       = CW + 2;
    localparam int E_START  = EW - 1;
    localparam int E_USED   = EW - 2;
    localparam int BW       = (POOL_LOG > 20 ? POOL_LOG : 20) + 1;
    localparam int OW       = (POOL_LOG > bba_pkg::ADDR_W ? POOL_LOG : bba_pkg::ADDR_W) + 1;
    localparam int NW       = 18;

    localparam logic [3:0] ST_CLR    = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_A_RD   = 4'd2;
    localparam logic [3:0] ST_A_CHK  = 4'd3;
    localparam logic [3:0] ST_A_SPL  = 4'd4;
    localparam logic [3:0] ST_F_RD   = 4'd5;
    localparam logic [3:0] ST_F_CHK  = 4'd6;
    localparam logic [3:0] ST_F_BRD  = 4'd7;
    localparam logic [3:0] ST_F_BCHK = 4'd8;
    localparam logic [3:0] ST_F_MRG  = 4'd9;
    localparam logic [3:0] ST_OUT    = 4'd10;

    function automatic logic [BW-1:0] blk_bytes(input logic [CW-1:0] c);
        blk_bytes = BW'(1) << (int'(c) + UNIT_LOG);
    endfunction

    logic [3:0]                 state_reg, state_next;
    logic [AW-1:0]              idx_reg, idx_next;
    logic [CW-1:0]              code_reg, code_next;
    logic [NW-1:0]              need_reg, need_next;
    logic [BW-1:0]              used_reg, used_next;
    logic                       res_ok_reg, res_ok_next;
    logic [bba_pkg::ADDR_W-1:0] res_addr_reg, res_addr_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       ok_reg, ok_next;
    logic [bba_pkg::ADDR_W-1:0] address_reg, address_next;
    logic [bba_pkg::USED_W-1:0] used_bytes_reg, used_bytes_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;

    logic [NW-1:0] req_min, need_c;
    logic [OW-1:0] off_c;
    logic          free_ok_c;
    logic [AW-1:0] bud_bit, bud_idx;
    logic [AW:0]   scan_nxt;
    logic [CW-1:0] rd_code;
    logic [OW-1:0] pay_off;

    bba_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_hdr_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign ok         = ok_reg;
    assign address    = address_reg;
    assign used_bytes = used_bytes_reg;

    assign rd_code  = rdata[CW-1:0];
    assign bud_bit  = AW'(1) << code_reg;
    assign bud_idx  = idx_reg ^ bud_bit;
    assign raddr    = (state_reg == ST_F_BRD) ? bud_idx : idx_reg;
    assign scan_nxt = {1'b0, idx_reg} + ((AW + 1)'(1) << rd_code);
    assign pay_off  = (OW'(idx_reg) << UNIT_LOG) + OW'(HEADER_BYTES);

    always_comb
    begin
        req_min = (request_bytes < bba_pkg::REQ_W'(MIN_REQUEST_BYTES)) ?
                  NW'(MIN_REQUEST_BYTES) : NW'(request_bytes);
        need_c  = ((req_min + NW'(7)) & ~NW'(7)) + NW'(HEADER_BYTES);
        off_c   = OW'(free_address) - OW'(HEADER_BYTES);
        free_ok_c = (OW'(free_address) >= OW'(HEADER_BYTES))
                 && (off_c[UNIT_LOG-1:0] == '0)
                 && (off_c < OW'(POOL_BYTES));
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        code_next       = code_reg;
        need_next       = need_reg;
        used_next       = used_reg;
        res_ok_next     = res_ok_reg;
        res_addr_next   = res_addr_reg;
        out_valid_next  = out_valid_reg;
        ok_next         = ok_reg;
        address_next    = address_reg;
        used_bytes_next = used_bytes_reg;
        we              = 1'b0;
        waddr           = idx_reg;
        wdata           = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLR:
            begin
                we    = 1'b1;
                wdata = (idx_reg == '0) ? {1'b1, 1'b0, CW'(TOP_CODE)} : '0;
                idx_next = idx_reg + AW'(1);
                if (idx_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    res_ok_next   = 1'b0;
                    res_addr_next = '0;
                    state_next    = ST_OUT;
                    case (command)
                        bba_pkg::CMD_ALLOC:
                        begin
                            need_next = need_c;
                            idx_next  = '0;
                            if (BW'(need_c) <= BW'(MAX_BLOCK_BYTES))
                            begin
                                state_next = ST_A_RD;
                            end
                        end
                        bba_pkg::CMD_FREE:
                        begin
                            idx_next = AW'(off_c >> UNIT_LOG);
                            if (free_ok_c)
                            begin
                                state_next = ST_F_RD;
                            end
                        end
                        bba_pkg::CMD_REPORT:
                        begin
                            res_ok_next = 1'b1;
                        end
                        default:
                        begin
                            res_ok_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_A_RD:
            begin
                state_next = ST_A_CHK;
            end
            ST_A_CHK:
            begin
                if (!rdata[E_START])
                begin
                    state_next = ST_OUT;
                end
                else if (!rdata[E_USED] && blk_bytes(rd_code) >= BW'(need_reg))
                begin
                    code_next  = rd_code;
                    state_next = ST_A_SPL;
                end
                else if (scan_nxt[AW])
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    idx_next   = scan_nxt[AW-1:0];
                    state_next = ST_A_RD;
                end
            end
            ST_A_SPL:
            begin
                we = 1'b1;
                if (code_reg != '0 && blk_bytes(code_reg - CW'(1)) >= BW'(need_reg))
                begin
                    waddr     = idx_reg + (AW'(1) << (code_reg - CW'(1)));
                    wdata     = {1'b1, 1'b0, code_reg - CW'(1)};
                    code_next = code_reg - CW'(1);
                end
                else
                begin
                    wdata         = {1'b1, 1'b1, code_reg};
                    used_next     = used_reg + blk_bytes(code_reg);
                    res_ok_next   = 1'b1;
                    res_addr_next = pay_off[bba_pkg::ADDR_W-1:0];
                    state_next    = ST_OUT;
                end
            end
            ST_F_RD:
            begin
                state_next = ST_F_CHK;
            end
            ST_F_CHK:
            begin
                if (rdata[E_START] && rdata[E_USED])
                begin
                    we          = 1'b1;
                    wdata       = {1'b1, 1'b0, rd_code};
                    used_next   = used_reg - blk_bytes(rd_code);
                    code_next   = rd_code;
                    res_ok_next = 1'b1;
                    state_next  = ST_F_BRD;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_F_BRD:
            begin
                if (code_reg < CW'(TOP_CODE)
                    && blk_bytes(code_reg) < BW'(MAX_BLOCK_BYTES))
                begin
                    state_next = ST_F_BCHK;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_F_BCHK:
            begin
                if (rdata[E_START] && !rdata[E_USED] && rd_code == code_reg)
                begin
                    we         = 1'b1;
                    waddr      = idx_reg | bud_bit;
                    wdata      = '0;
                    state_next = ST_F_MRG;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_F_MRG:
            begin
                we         = 1'b1;
                waddr      = idx_reg & ~bud_bit;
                wdata      = {1'b1, 1'b0, code_reg + CW'(1)};
                idx_next   = idx_reg & ~bud_bit;
                code_next  = code_reg + CW'(1);
                state_next = ST_F_BRD;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    ok_next         = res_ok_reg;
                    address_next    = res_ok_reg ? res_addr_reg : '0;
                    used_bytes_next = used_reg[bba_pkg::USED_W-1:0];
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            idx_reg       <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg       <= code_next;
        need_reg       <= need_next;
        res_ok_reg     <= res_ok_next;
        res_addr_reg   <= res_addr_next;
        ok_reg         <= ok_next;
        address_reg    <= address_next;
        used_bytes_reg <= used_bytes_next;
    end

    a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= BW'(POOL_BYTES))
        else $error("used total beyond pool");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !we)
        else $error("header write while idle");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != ST_IDLE))
        else $error("item accepted but not processed");

endmodule
